>>> rtl/rmq_pkg.sv
// ---------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix to quaternion pipeline
// Field widths, lane numbering, width helpers and the sign flag bundle.
// ---------------------------------------------------------------------------
package rmq_pkg;

  // default number of fraction bits (q2.14)
  localparam int FRAC_BITS_DEF = 14;

  // fixed field widths
  localparam int IN_W  = 16;
  localparam int QW_W  = 15;
  localparam int QV_W  = 16;

  // largest magnitude a result field can carry
  localparam logic [QW_W-1:0] MAG_MAX = 15'h7fff;

  // one square root lane per quaternion part
  localparam int LANES  = 4;
  localparam int LANE_W = 0;
  localparam int LANE_X = 1;
  localparam int LANE_Y = 2;
  localparam int LANE_Z = 3;

  // signed width of one plus three diagonal entries
  function automatic int sum_width(input int frac);
    return ((frac > 17) ? frac : 17) + 2;
  endfunction

  // radicand width: clamped sum shifted up by frac, rounded up to even
  function automatic int rad_width(input int frac);
    return ((sum_width(frac) - 1 + frac + 1) / 2) * 2;
  endfunction

  // sign flags carried beside the roots
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } sign_t;

endpackage

>>> rtl/rmq_if.sv
// ---------------------------------------------------------------------------
// rmq_if: item channels of the matrix to quaternion pipeline
// Input channel carries nine matrix entries, output channel one quaternion.
// ---------------------------------------------------------------------------
interface rmq_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [rmq_pkg::IN_W-1:0] m00;
  logic signed [rmq_pkg::IN_W-1:0] m01;
  logic signed [rmq_pkg::IN_W-1:0] m02;
  logic signed [rmq_pkg::IN_W-1:0] m10;
  logic signed [rmq_pkg::IN_W-1:0] m11;
  logic signed [rmq_pkg::IN_W-1:0] m12;
  logic signed [rmq_pkg::IN_W-1:0] m20;
  logic signed [rmq_pkg::IN_W-1:0] m21;
  logic signed [rmq_pkg::IN_W-1:0] m22;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  ready
  );
  modport sink (
    input  valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
    output ready
  );
endinterface

interface rmq_out_if;
  logic                           valid;
  logic                           ready;
  logic        [rmq_pkg::QW_W-1:0] quat_w;
  logic signed [rmq_pkg::QV_W-1:0] quat_x;
  logic signed [rmq_pkg::QV_W-1:0] quat_y;
  logic signed [rmq_pkg::QV_W-1:0] quat_z;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z,
    output ready
  );
endinterface

>>> rtl/rotation_matrix_to_quaternion.sv
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to quaternion
// Fixed-point copysign conversion, one item per cycle when not stalled, fully pipelined.
// ---------------------------------------------------------------------------
// usage
//   in_if  : valid/ready channel carrying m00..m22, signed fixed point with
//            FRAC_BITS fraction bits; an item moves when valid and ready are
//            both high at a rising edge of clk
//   out_if : valid/ready channel carrying quat_w (unsigned) and the signed
//            quat_x, quat_y, quat_z in the same format
//   digits : ROOT_W, the number of root digits, is half the radicand width
//            (16 at FRAC_BITS = 14)
//   rate   : one item per cycle unless stalled; every item flows through a
//            sum stage, one stage per root digit (four square roots side by
//            side) and an output stage, each holding its own valid bit
//   stall  : when out_if.ready is low the output register holds its item;
//            stages behind it keep filling empty slots, so in_if.ready only
//            drops once every stage holds an item; nothing is lost or repeated
//   reset  : synchronous, active low on rst_n; all valid bits clear, so the
//            pipeline comes out empty and ready
// ---------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rmq_in_if.sink     in_if,
  rmq_out_if.source  out_if
);

  // radicand is the clamped sum shifted up by FRAC_BITS
  localparam int RAD_W  = rmq_pkg::rad_width(FRAC_BITS);
  localparam int ROOT_W = RAD_W / 2;

  // stage k feeds root digit k; index ROOT_W is the last root register
  logic                                  stg_valid [ROOT_W+1];
  logic                                  stg_ready [ROOT_W+1];
  logic [rmq_pkg::LANES-1:0][RAD_W-1:0]  stg_rad   [ROOT_W+1];
  logic [rmq_pkg::LANES-1:0][ROOT_W+1:0] stg_rem   [ROOT_W+1];
  logic [rmq_pkg::LANES-1:0][ROOT_W-1:0] stg_root  [ROOT_W+1];
  rmq_pkg::sign_t                        stg_sign  [ROOT_W+1];

  // front: diagonal sums, clamp, sign of the off-diagonal differences
  rmq_sum_stage #(
    .FRAC_BITS (FRAC_BITS),
    .RAD_W     (RAD_W)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .rad_o     (stg_rad[0]),
    .sign_o    (stg_sign[0])
  );

  // root and remainder start from zero
  assign stg_rem[0]  = '0;
  assign stg_root[0] = '0;

  // one root bit per stage, msb first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    rmq_root_step #(
      .RAD_W  (RAD_W),
      .ROOT_W (ROOT_W)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[k]),
      .in_ready  (stg_ready[k]),
      .rad_i     (stg_rad[k]),
      .rem_i     (stg_rem[k]),
      .root_i    (stg_root[k]),
      .sign_i    (stg_sign[k]),
      .out_valid (stg_valid[k+1]),
      .out_ready (stg_ready[k+1]),
      .rad_o     (stg_rad[k+1]),
      .rem_o     (stg_rem[k+1]),
      .root_o    (stg_root[k+1]),
      .sign_o    (stg_sign[k+1])
    );
  end

  // back: halve, saturate, apply sign, output register
  rmq_out_stage #(
    .ROOT_W (ROOT_W)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stg_valid[ROOT_W]),
    .in_ready (stg_ready[ROOT_W]),
    .root_i   (stg_root[ROOT_W]),
    .sign_i   (stg_sign[ROOT_W]),
    .out_if   (out_if)
  );

  // magnitudes saturate at the positive limit, so no result is the most
  // negative code
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.quat_x != 16'sh8000) && (out_if.quat_y != 16'sh8000)
                     && (out_if.quat_z != 16'sh8000))
    else $error("quaternion part at most negative code");

  // an empty front stage always takes an item
  a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !stg_valid[0] |-> in_if.ready)
    else $error("front stage empty but not ready");

  // the front stage and the output register come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_if.valid && !stg_valid[0])
    else $error("valid item right after reset");

  // the last root stage keeps its item while stalled
  a_root_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[ROOT_W] && !stg_ready[ROOT_W] |=> stg_valid[ROOT_W]
                                              && $stable(stg_root[ROOT_W]))
    else $error("last root stage dropped a stalled item");

endmodule

>>> rtl/rmq_sum_stage.sv
// ---------------------------------------------------------------------------
// rmq_sum_stage: diagonal sums, clamp and sign flags
// Forms the four radicands and the three off-diagonal signs, registered.
// ---------------------------------------------------------------------------
module rmq_sum_stage #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int RAD_W     = rmq_pkg::rad_width(rmq_pkg::FRAC_BITS_DEF)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  rmq_in_if.sink                                in_if,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rmq_pkg::LANES-1:0][RAD_W-1:0]  rad_o,
  output rmq_pkg::sign_t                        sign_o
);

  localparam int SUM_W = rmq_pkg::sum_width(FRAC_BITS);
  localparam int MAG_W = SUM_W - 1;
  localparam logic signed [SUM_W-1:0] ONE = SUM_W'(1) << FRAC_BITS;

  logic signed [SUM_W-1:0] e00, e11, e22;
  logic signed [SUM_W-1:0] sum_l [rmq_pkg::LANES];
  logic [MAG_W-1:0] mag_l [rmq_pkg::LANES];

  logic                                 v_r;
  logic [rmq_pkg::LANES-1:0][RAD_W-1:0] rad_r, rad_nxt;
  rmq_pkg::sign_t                       sign_r, sign_nxt;

  assign e00 = SUM_W'(in_if.m00);
  assign e11 = SUM_W'(in_if.m11);
  assign e22 = SUM_W'(in_if.m22);

  always_comb begin
    sum_l[rmq_pkg::LANE_W] = ONE + e00 + e11 + e22;
    sum_l[rmq_pkg::LANE_X] = ONE + e00 - e11 - e22;
    sum_l[rmq_pkg::LANE_Y] = ONE - e00 + e11 - e22;
    sum_l[rmq_pkg::LANE_Z] = ONE - e00 - e11 + e22;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      // a sum at or below zero gives a zero root
      if (sum_l[l][SUM_W-1] || (sum_l[l] == '0)) begin
        mag_l[l] = '0;
      end else begin
        mag_l[l] = sum_l[l][MAG_W-1:0];
      end
      rad_nxt[l] = RAD_W'({mag_l[l], {FRAC_BITS{1'b0}}});
    end
    sign_nxt.neg_x = in_if.m21 < in_if.m12;
    sign_nxt.neg_y = in_if.m02 < in_if.m20;
    sign_nxt.neg_z = in_if.m10 < in_if.m01;
  end

  assign in_if.ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_if.ready) begin
      v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      rad_r  <= rad_nxt;
      sign_r <= sign_nxt;
    end
  end

  assign out_valid = v_r;
  assign rad_o     = rad_r;
  assign sign_o    = sign_r;

endmodule

>>> rtl/rmq_root_step.sv
// ---------------------------------------------------------------------------
// rmq_root_step: one digit of the restoring square root, four lanes
// Brings in two radicand bits and decides one root bit per lane.
// ---------------------------------------------------------------------------
module rmq_root_step #(
  parameter int RAD_W  = rmq_pkg::rad_width(rmq_pkg::FRAC_BITS_DEF),
  parameter int ROOT_W = rmq_pkg::rad_width(rmq_pkg::FRAC_BITS_DEF) / 2
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [rmq_pkg::LANES-1:0][RAD_W-1:0]    rad_i,
  input  logic [rmq_pkg::LANES-1:0][ROOT_W+1:0]   rem_i,
  input  logic [rmq_pkg::LANES-1:0][ROOT_W-1:0]   root_i,
  input  rmq_pkg::sign_t                          sign_i,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [rmq_pkg::LANES-1:0][RAD_W-1:0]    rad_o,
  output logic [rmq_pkg::LANES-1:0][ROOT_W+1:0]   rem_o,
  output logic [rmq_pkg::LANES-1:0][ROOT_W-1:0]   root_o,
  output rmq_pkg::sign_t                          sign_o
);

  logic [ROOT_W+1:0] rem_sh [rmq_pkg::LANES];
  logic [ROOT_W+1:0] trial  [rmq_pkg::LANES];

  logic                                  v_r;
  logic [rmq_pkg::LANES-1:0][RAD_W-1:0]  rad_r, rad_nxt;
  logic [rmq_pkg::LANES-1:0][ROOT_W+1:0] rem_r, rem_nxt;
  logic [rmq_pkg::LANES-1:0][ROOT_W-1:0] root_r, root_nxt;
  rmq_pkg::sign_t                        sign_r;

  always_comb begin
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      rem_sh[l] = {rem_i[l][ROOT_W-1:0], rad_i[l][RAD_W-1 -: 2]};
      trial[l]  = {root_i[l], 2'b01};
      if (rem_sh[l] >= trial[l]) begin
        rem_nxt[l]  = rem_sh[l] - trial[l];
        root_nxt[l] = {root_i[l][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[l]  = rem_sh[l];
        root_nxt[l] = {root_i[l][ROOT_W-2:0], 1'b0};
      end
      rad_nxt[l] = {rad_i[l][RAD_W-3:0], 2'b00};
    end
  end

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      sign_r <= sign_i;
    end
  end

  assign out_valid = v_r;
  assign rad_o     = rad_r;
  assign rem_o     = rem_r;
  assign root_o    = root_r;
  assign sign_o    = sign_r;

endmodule

>>> rtl/rmq_out_stage.sv
// ---------------------------------------------------------------------------
// rmq_out_stage: halve, saturate and sign the roots
// Output register of the pipeline, drives the result channel.
// ---------------------------------------------------------------------------
module rmq_out_stage #(
  parameter int ROOT_W = rmq_pkg::rad_width(rmq_pkg::FRAC_BITS_DEF) / 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [rmq_pkg::LANES-1:0][ROOT_W-1:0]  root_i,
  input  rmq_pkg::sign_t                         sign_i,
  rmq_out_if.source                              out_if
);

  localparam int HALF_W = ROOT_W - 1;
  localparam int CMP_W  = (HALF_W > rmq_pkg::QV_W) ? HALF_W : rmq_pkg::QV_W;

  logic [HALF_W-1:0]        half_l [rmq_pkg::LANES];
  logic [rmq_pkg::QW_W-1:0] mag_l  [rmq_pkg::LANES];
  logic [rmq_pkg::QV_W-1:0] ext_l  [rmq_pkg::LANES];

  logic                            v_r;
  logic [rmq_pkg::QW_W-1:0]        qw_r, qw_nxt;
  logic signed [rmq_pkg::QV_W-1:0] qx_r, qx_nxt;
  logic signed [rmq_pkg::QV_W-1:0] qy_r, qy_nxt;
  logic signed [rmq_pkg::QV_W-1:0] qz_r, qz_nxt;

  always_comb begin
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      half_l[l] = root_i[l][ROOT_W-1:1];
      if (CMP_W'(half_l[l]) > CMP_W'(rmq_pkg::MAG_MAX)) begin
        mag_l[l] = rmq_pkg::MAG_MAX;
      end else begin
        mag_l[l] = rmq_pkg::QW_W'(half_l[l]);
      end
      ext_l[l] = {1'b0, mag_l[l]};
    end
    qw_nxt = mag_l[rmq_pkg::LANE_W];
    // negating a zero magnitude stays zero
    qx_nxt = sign_i.neg_x ? ('0 - ext_l[rmq_pkg::LANE_X]) : ext_l[rmq_pkg::LANE_X];
    qy_nxt = sign_i.neg_y ? ('0 - ext_l[rmq_pkg::LANE_Y]) : ext_l[rmq_pkg::LANE_Y];
    qz_nxt = sign_i.neg_z ? ('0 - ext_l[rmq_pkg::LANE_Z]) : ext_l[rmq_pkg::LANE_Z];
  end

  assign in_ready = !v_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      qw_r <= qw_nxt;
      qx_r <= qx_nxt;
      qy_r <= qy_nxt;
      qz_r <= qz_nxt;
    end
  end

  assign out_if.valid  = v_r;
  assign out_if.quat_w = qw_r;
  assign out_if.quat_x = qx_r;
  assign out_if.quat_y = qy_r;
  assign out_if.quat_z = qz_r;

endmodule
